// File: sv/dmx_channel_fade_engine_top_assert.svh
// ----------------------------------------------------------------------------
// dmx_channel_fade_engine_top_assert.svh
// Assertion macros for the fade engine port checker.
// ----------------------------------------------------------------------------
`ifndef DMX_CHANNEL_FADE_ENGINE_TOP_ASSERT_SVH
`define DMX_CHANNEL_FADE_ENGINE_TOP_ASSERT_SVH

// Clocked check, off while in reset.
`define DCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define DCFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/dcfe_pkg.sv
// ----------------------------------------------------------------------------
// dcfe_pkg
// Types and constants shared by the DMX channel fade engine.
// ----------------------------------------------------------------------------
package dcfe_pkg;

  localparam int NUM_CHANNELS_DEF = 512;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int CH_W     = 9;
  localparam int BRIGHT_W = 8;
  localparam int TCS_W    = 16;
  localparam int FPS_W    = 7;
  localparam int CFG_IX_W = 2;

  localparam logic [FPS_W-1:0]    FPS_RESET     = 7'd40;
  localparam logic [TCS_W-1:0]    DEF_TCS_RESET = 16'd100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET  = 8'd255;

  // frames = floor(tcs * fps / 100) via reciprocal: ceil(2^30 / 100)
  localparam int PROD_W   = TCS_W + FPS_W;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 30;
  localparam int FRAMES_W = PROD_W + RECIP_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP_K = 24'd10737419;

  typedef enum logic [1:0] {
    CMD_ON     = 2'd0,
    CMD_OFF    = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_FPS     = 2'd0,
    CFG_DEF_TCS = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RENDER,
    ST_SWITCH,
    ST_FRAMES,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [CH_W-1:0]     channel;
    logic [BRIGHT_W-1:0] brightness;
    logic                brightness_given;
    logic [TCS_W-1:0]    transition_cs;
    logic                transition_given;
  } cmd_word_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [BRIGHT_W-1:0] level;
    logic                fade_done;
  } res_word_t;

  typedef struct packed {
    logic [CFG_IX_W-1:0] index;
    logic [TCS_W-1:0]    value;
  } cfg_word_t;

endpackage

// File: sv/dcfe_stream_if.sv
// ----------------------------------------------------------------------------
// dcfe_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface dcfe_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/dcfe_mem.sv
// ----------------------------------------------------------------------------
// dcfe_mem
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module dcfe_mem #(
  parameter int WORD_W = 8,
  parameter int DEPTH  = 2,
  parameter int AW     = 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dcfe_frames.sv
// ----------------------------------------------------------------------------
// dcfe_frames
// Two-stage frame count: tcs * fps, then divide by 100 via reciprocal.
// ----------------------------------------------------------------------------
module dcfe_frames
  import dcfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [TCS_W-1:0]    tcs_i,
  input  logic [FPS_W-1:0]    fps_i,
  output logic                done_o,
  output logic [FRAMES_W-1:0] frames_o
);

  localparam int FULL_W = PROD_W + RECIP_W;

  logic                v_d, v_q, done_d, done_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic [FULL_W-1:0]   full_w;
  logic [FRAMES_W-1:0] quo_w, frames_d, frames_q;

  always_comb begin
    prod_d   = prod_q;
    frames_d = frames_q;
    v_d      = start_i;
    done_d   = v_q;
    if (start_i) begin
      prod_d = PROD_W'(tcs_i) * PROD_W'(fps_i);
    end
    full_w = FULL_W'(prod_q) * FULL_W'(RECIP_K);
    quo_w  = full_w[RECIP_SH +: FRAMES_W];
    if (v_q) begin
      frames_d = (quo_w == '0) ? FRAMES_W'(1) : quo_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_q    <= v_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    frames_q <= frames_d;
  end

  assign done_o   = done_q;
  assign frames_o = frames_q;

endmodule

// File: sv/dcfe_div.sv
// ----------------------------------------------------------------------------
// dcfe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcfe_div #(
  parameter int N   = 24,
  parameter int D_W = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N-1:0]   dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N-1:0]   quot_o
);

  localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

  logic             busy_d, busy_q, done_d, done_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [N-1:0]     quot_d, quot_q;
  logic [D_W-1:0]   rem_d, rem_q, dvs_d, dvs_q;
  logic [D_W:0]     trial_w;
  logic [D_W+1:0]   sub_w;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    trial_w = {rem_q, quot_q[N-1]};
    sub_w   = {1'b0, trial_w} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (sub_w[D_W+1]) begin
        rem_d  = trial_w[D_W-1:0];
        quot_d = {quot_q[N-2:0], 1'b0};
      end else begin
        rem_d  = sub_w[D_W-1:0];
        quot_d = {quot_q[N-2:0], 1'b1};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: sv/dmx_channel_fade_engine_top.sv
// ----------------------------------------------------------------------------
// dmx_channel_fade_engine_top
// Per-channel linear fade engine: switch-on/off commands set target and step,
// render commands advance one channel and return its level.
// ----------------------------------------------------------------------------
//  port    dir   word         meaning
//  cmd_i   in    cmd_word_t   switch-on, switch-off, render
//  res_o   out   res_word_t   rendered channel level
//  cfg_i   in    cfg_word_t   register write (index, value)
//
//  Render: memory read, then update and write-back.
//  Switch: a zero transition or no change is written directly; otherwise the
//  frame count, then the bit-serial divider (8 + FRAC_BITS steps), set the step.
//  After reset a pass clears all NUM_CHANNELS entries; cmd_i is not ready.
//  A render waits in place while a previous result is held on res_o.
// ----------------------------------------------------------------------------
module dmx_channel_fade_engine_top
  import dcfe_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcfe_stream_if.sink   cmd_i,
  dcfe_stream_if.source res_o,
  dcfe_stream_if.sink   cfg_i
);

  localparam int LVL_W  = BRIGHT_W + FRAC_BITS;
  localparam int STEP_W = LVL_W + 1;
  localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WORD_W = LVL_W + STEP_W + 2 * BRIGHT_W;

  typedef struct packed {
    logic [LVL_W-1:0]    level;
    logic [STEP_W-1:0]   step;
    logic [BRIGHT_W-1:0] target;
    logic [BRIGHT_W-1:0] bright;
  } entry_t;

  typedef struct packed {
    logic [LVL_W-1:0]    level;
    logic [BRIGHT_W-1:0] target;
    logic [BRIGHT_W-1:0] bright;
    logic                neg;
    logic [LVL_W-1:0]    mag;
  } work_t;

  state_e         state_d, state_q;
  logic [AW-1:0]  clr_cnt_d, clr_cnt_q;
  cmd_word_t      cmd_q;
  logic           ch_ok_q, ch_in_ok;
  work_t          wk_d, wk_q;
  logic           res_valid_d, res_valid_q;
  res_word_t      res_d, res_q;
  logic [FPS_W-1:0] fps_q;
  logic [TCS_W-1:0] def_tcs_q;

  logic              cmd_ready, slot_free;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata, rd_e;
  logic [WORD_W-1:0] mem_rdata;

  logic                frames_start, frames_done;
  logic [FRAMES_W-1:0] frames;
  logic                div_start, div_done;
  logic [LVL_W-1:0]    div_quot;

  // render datapath
  logic                     step_nz, step_neg, hit;
  logic signed [STEP_W:0]   sum_w, tgt_w;
  logic [LVL_W-1:0]         new_level;
  logic [STEP_W-1:0]        new_step;

  // switch datapath
  logic [BRIGHT_W-1:0]      bright_new, tgt_new;
  logic [TCS_W-1:0]         tcs_sel;
  logic [LVL_W-1:0]         tgt_fix;
  logic signed [STEP_W-1:0] diff_w, ndiff_w;
  logic [LVL_W-1:0]         diff_mag;
  logic [LVL_W-1:0]         q_mag;
  logic [STEP_W-1:0]        step_fin;

  assign ch_in_ok = {1'b0, cmd_i.data.channel} < (CH_W + 1)'(NUM_CHANNELS);
  assign rd_e     = entry_t'(mem_rdata);

  always_comb begin
    step_nz   = |rd_e.step;
    step_neg  = rd_e.step[STEP_W-1];
    sum_w     = $signed({2'b00, rd_e.level}) + $signed({rd_e.step[STEP_W-1], rd_e.step});
    tgt_w     = $signed({2'b00, rd_e.target, {FRAC_BITS{1'b0}}});
    hit       = step_nz && ((!step_neg && (sum_w >= tgt_w)) || (step_neg && (sum_w <= tgt_w)));
    new_step  = hit ? '0 : rd_e.step;
    if (!step_nz) begin
      new_level = rd_e.level;
    end else if (hit) begin
      new_level = {rd_e.target, {FRAC_BITS{1'b0}}};
    end else begin
      new_level = sum_w[LVL_W-1:0];
    end

    bright_new = (cmd_q.command == CMD_ON && cmd_q.brightness_given) ?
                 cmd_q.brightness : rd_e.bright;
    tgt_new    = (cmd_q.command == CMD_ON) ? bright_new : '0;
    tcs_sel    = cmd_q.transition_given ? cmd_q.transition_cs : def_tcs_q;
    tgt_fix    = {tgt_new, {FRAC_BITS{1'b0}}};
    diff_w     = $signed({1'b0, tgt_fix}) - $signed({1'b0, rd_e.level});
    ndiff_w    = -diff_w;
    diff_mag   = diff_w[STEP_W-1] ? ndiff_w[LVL_W-1:0] : diff_w[LVL_W-1:0];

    q_mag    = (div_quot == '0) ? LVL_W'(1) : div_quot;
    step_fin = wk_q.neg ? -{1'b0, q_mag} : {1'b0, q_mag};
  end

  assign slot_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    cmd_ready    = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cmd_q.channel[AW-1:0];
    mem_wdata    = rd_e;
    wk_d         = wk_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_d        = res_q;
    frames_start = 1'b0;
    div_start    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '{level: '0, step: '0, target: '0, bright: BRIGHT_RESET};
        if (clr_cnt_q == AW'(NUM_CHANNELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_i.valid) begin
          mem_re = ch_in_ok;
          if (cmd_i.data.command == CMD_RENDER) begin
            state_d = ST_RENDER;
          end else if (ch_in_ok && (cmd_i.data.command == CMD_ON ||
                                    cmd_i.data.command == CMD_OFF)) begin
            state_d = ST_SWITCH;
          end
        end
      end
      ST_RENDER: begin
        if (slot_free) begin
          res_valid_d       = 1'b1;
          res_d.out_channel = cmd_q.channel;
          res_d.level       = ch_ok_q ? new_level[LVL_W-1:FRAC_BITS] : '0;
          res_d.fade_done   = ch_ok_q && hit;
          mem_we            = ch_ok_q && step_nz;
          mem_wdata         = '{level: new_level, step: new_step,
                                target: rd_e.target, bright: rd_e.bright};
          state_d           = ST_IDLE;
        end
      end
      ST_SWITCH: begin
        if (tcs_sel == '0 || diff_w == '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{level: (tcs_sel == '0) ? tgt_fix : rd_e.level, step: '0,
                        target: tgt_new, bright: bright_new};
          state_d   = ST_IDLE;
        end else begin
          wk_d         = '{level: rd_e.level, target: tgt_new, bright: bright_new,
                           neg: diff_w[STEP_W-1], mag: diff_mag};
          frames_start = 1'b1;
          state_d      = ST_FRAMES;
        end
      end
      ST_FRAMES: begin
        if (frames_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = '{level: wk_q.level, step: step_fin,
                        target: wk_q.target, bright: wk_q.bright};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      fps_q       <= FPS_RESET;
      def_tcs_q   <= DEF_TCS_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          CFG_FPS:     fps_q     <= cfg_i.data.value[FPS_W-1:0];
          CFG_DEF_TCS: def_tcs_q <= cfg_i.data.value;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_ready) begin
      cmd_q   <= cmd_i.data;
      ch_ok_q <= ch_in_ok;
    end
    wk_q  <= wk_d;
    res_q <= res_d;
  end

  dcfe_mem #(
    .WORD_W (WORD_W),
    .DEPTH  (NUM_CHANNELS),
    .AW     (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cmd_i.data.channel[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  dcfe_frames u_frames (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (frames_start),
    .tcs_i    (tcs_sel),
    .fps_i    (fps_q),
    .done_o   (frames_done),
    .frames_o (frames)
  );

  dcfe_div #(
    .N   (LVL_W),
    .D_W (FRAMES_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wk_q.mag),
    .divisor_i  (frames),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cmd_i.ready = cmd_ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;
  assign cfg_i.ready = 1'b1;

endmodule

// File: sv/dcfe_chk.sv
// ----------------------------------------------------------------------------
// dcfe_chk
// Port-level checker for the fade engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "dmx_channel_fade_engine_top_assert.svh"

module dcfe_chk
  import dcfe_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cmd_valid_i,
  input logic      cmd_ready_i,
  input logic [1:0] cmd_command_i,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input res_word_t res_data_i
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  `DCFE_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i), "result word changed while stalled")
  `DCFE_ASSERT(a_res_from_render, $rose(res_valid_i) |-> $past(cmd_acc && cmd_command_i == CMD_RENDER, 2), "result without a render word")
  `DCFE_ASSERT(a_bad_ch_zero, res_valid_i && (res_data_i.out_channel >= NUM_CHANNELS) |-> res_data_i.level == '0 && !res_data_i.fade_done, "out-of-range channel gave a level")
  `DCFE_ASSERT(a_one_at_a_time, cmd_acc && cmd_command_i == CMD_RENDER |=> !cmd_ready_i, "command taken while busy")
  `DCFE_ASSERT_RST(a_no_cmd_in_reset, !rst_ni |-> !cmd_ready_i, "command ready during reset")

endmodule

bind dmx_channel_fade_engine_top dcfe_chk #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_dcfe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .cmd_command_i (cmd_i.data.command),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_data_i    (res_o.data)
);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DMX channel fade engine. A behavioral model
// tracks level, step, target and remembered brightness per channel and
// predicts every render word. Directed edge cases come first, then
// backpressure, then randomized fade sequences under several register
// settings, with random idling on both channels in all but the last.
// ----------------------------------------------------------------------------
module tb;
  import dcfe_pkg::*;

  localparam int NUM_CH        = NUM_CHANNELS_DEF;
  localparam int FRAC          = FRAC_BITS_DEF;
  localparam int LVL_W         = BRIGHT_W + FRAC;
  localparam int STEP_W        = LVL_W + 1;
  localparam int CMD_W         = $bits(cmd_word_t);
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;

  // register indexes with no register behind them
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcfe_stream_if #(.word_t(cmd_word_t)) cmd_if ();
  dcfe_stream_if #(.word_t(res_word_t)) res_if ();
  dcfe_stream_if #(.word_t(cfg_word_t)) cfg_if ();

  dmx_channel_fade_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // channel model
  logic [LVL_W-1:0]         chan_level  [NUM_CH];
  logic signed [STEP_W-1:0] chan_step   [NUM_CH];
  logic [BRIGHT_W-1:0]      chan_target [NUM_CH];
  logic [BRIGHT_W-1:0]      chan_bright [NUM_CH];
  logic [FPS_W-1:0]         fps_reg;
  logic [TCS_W-1:0]         def_tcs_reg;

  res_word_t   pending_levels [$];
  res_word_t   exp_word;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  int unsigned focus_ch [4];
  bit          src_idle  = 1'b1;
  bit          sink_idle = 1'b1;
  bit          hold_req  = 1'b0;

  function automatic void reset_model();
    for (int i = 0; i < NUM_CH; i++) begin
      chan_level[i]  = '0;
      chan_step[i]   = '0;
      chan_target[i] = '0;
      chan_bright[i] = BRIGHT_RESET;
    end
    fps_reg     = FPS_RESET;
    def_tcs_reg = DEF_TCS_RESET;
  endfunction

  function automatic void start_fade(int unsigned ch, logic [TCS_W-1:0] tcs);
    longint diff, frames, stp;
    diff = (longint'(chan_target[ch]) << FRAC) - longint'(chan_level[ch]);
    if (tcs == '0) begin
      chan_level[ch] = {chan_target[ch], {FRAC{1'b0}}};
      chan_step[ch]  = '0;
      return;
    end
    if (diff == 0) begin
      chan_step[ch] = '0;
      return;
    end
    frames = (longint'(tcs) * longint'(fps_reg)) / 100;
    if (frames < 1)
      frames = 1;
    stp = diff / frames;
    if (stp == 0)
      stp = (diff > 0) ? 1 : -1;
    chan_step[ch] = STEP_W'(stp);
  endfunction

  function automatic void apply_command(cmd_word_t w);
    int unsigned      ch;
    logic [TCS_W-1:0] tcs;
    longint           cur, tgt, stp;
    res_word_t        r;
    ch  = 32'(w.channel);
    tcs = w.transition_given ? w.transition_cs : def_tcs_reg;
    case (w.command)
      CMD_ON: begin
        if (w.brightness_given)
          chan_bright[ch] = w.brightness;
        chan_target[ch] = chan_bright[ch];
        start_fade(ch, tcs);
      end
      CMD_OFF: begin
        chan_target[ch] = '0;
        start_fade(ch, tcs);
      end
      CMD_RENDER: begin
        stp = longint'(chan_step[ch]);
        cur = longint'(chan_level[ch]);
        tgt = longint'(chan_target[ch]) << FRAC;
        r.fade_done = 1'b0;
        if (stp != 0) begin
          cur += stp;
          if ((stp > 0 && cur >= tgt) || (stp < 0 && cur <= tgt)) begin
            cur           = tgt;
            chan_step[ch] = '0;
            r.fade_done   = 1'b1;
          end
          chan_level[ch] = LVL_W'(cur);
        end
        r.out_channel = w.channel;
        r.level       = chan_level[ch][LVL_W-1 -: BRIGHT_W];
        pending_levels.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(logic [CFG_IX_W-1:0] ix, logic [TCS_W-1:0] v);
    case (ix)
      CFG_FPS:     fps_reg     = v[FPS_W-1:0];
      CFG_DEF_TCS: def_tcs_reg = v;
      default: ;
    endcase
  endfunction

  function automatic cmd_word_t mk_cmd(cmd_e c, int unsigned ch, int unsigned br,
                                       int unsigned bg, int unsigned tcs,
                                       int unsigned tg);
    cmd_word_t w;
    w.command          = c;
    w.channel          = CH_W'(ch);
    w.brightness       = BRIGHT_W'(br);
    w.brightness_given = 1'(bg);
    w.transition_cs    = TCS_W'(tcs);
    w.transition_given = 1'(tg);
    return w;
  endfunction

  function automatic int unsigned pick_channel();
    if ($urandom_range(0, 4) != 0)
      return focus_ch[$urandom_range(0, 3)];
    return $urandom_range(0, NUM_CH - 1);
  endfunction

  function automatic int unsigned pick_tcs();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return 0;
    if (r < 8)
      return $urandom_range(1, 150);
    if (r < 9)
      return $urandom_range(151, 2000);
    return $urandom_range(0, 65535);
  endfunction

  function automatic void shuffle_focus();
    for (int i = 0; i < 4; i++)
      focus_ch[i] = $urandom_range(0, NUM_CH - 1);
  endfunction

  // called at a falling edge; leaves valid high so back-to-back words stream
  task automatic send_cmd(input cmd_word_t w);
    if (src_idle && $urandom_range(0, 7) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    @(posedge clk_i);
    while (!cmd_if.ready)
      @(posedge clk_i);
    apply_command(w);
    if (w.command != CMD_NONE)
      items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [TCS_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_word_t'{index: ix, value: v};
    @(posedge clk_i);
    while (!cfg_if.ready)
      @(posedge clk_i);
    apply_reg(ix, v);
    @(negedge clk_i);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_levels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [FPS_W-1:0] fps, input logic [TCS_W-1:0] tcs);
    settle();
    write_reg(CFG_SPARE_A, TCS_W'($urandom));
    write_reg(CFG_FPS, {(TCS_W - FPS_W)'($urandom), fps});
    write_reg(CFG_DEF_TCS, tcs);
    write_reg(CFG_SPARE_B, TCS_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // reset values: 40 fps, 100 cs default, remembered brightness 255
  task automatic test_reset_defaults();
    send_cmd(mk_cmd(CMD_RENDER, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_ON, 0, 17, 0, 9, 0));
    send_cmd(mk_cmd(CMD_RENDER, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_ON, NUM_CH - 1, 255, 1, 0, 1));
    send_cmd(mk_cmd(CMD_RENDER, NUM_CH - 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_OFF, NUM_CH - 1, 0, 0, 0, 1));
    send_cmd(mk_cmd(CMD_NONE, NUM_CH - 1, 255, 1, 65535, 1));
    send_cmd(mk_cmd(CMD_RENDER, NUM_CH - 1, 255, 1, 65535, 1));
    send_cmd(mk_cmd(CMD_ON, 1, 0, 0, 1, 1));
    send_cmd(mk_cmd(CMD_RENDER, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_RENDER, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_ON, 1, 255, 1, 50, 1));
    send_cmd(mk_cmd(CMD_RENDER, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_OFF, 1, 0, 0, 65535, 1));
    send_cmd(mk_cmd(CMD_RENDER, 1, 0, 0, 0, 0));
  endtask

  // one-LSB steps both ways, zero frame rate, switch-off at zero
  task automatic test_fade_edges();
    set_regs(7'd127, 16'hFFFF);
    send_cmd(mk_cmd(CMD_ON, 4, 1, 1, 65535, 1));
    send_cmd(mk_cmd(CMD_RENDER, 4, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_OFF, 4, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_RENDER, 4, 0, 0, 0, 0));
    set_regs(7'd0, 16'd50);
    send_cmd(mk_cmd(CMD_ON, 5, 128, 1, 0, 0));
    send_cmd(mk_cmd(CMD_RENDER, 5, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_OFF, 6, 0, 0, 77, 1));
    send_cmd(mk_cmd(CMD_RENDER, 6, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    set_regs(FPS_RESET, DEF_TCS_RESET);
    shuffle_focus();
    hold_req = 1'b1;
    send_cmd(mk_cmd(CMD_ON, focus_ch[0], $urandom_range(1, 255), 1, 20, 1));
    for (int i = 0; i < 40; i++)
      send_cmd(mk_cmd(CMD_RENDER, focus_ch[i % 2], 0, 0, 0, 0));
  endtask

  task automatic run_fades(input int unsigned n);
    int unsigned      start, ch;
    logic [CMD_W-1:0] raw;
    shuffle_focus();
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) < 8) begin
        ch = pick_channel();
        send_cmd(mk_cmd(($urandom_range(0, 3) == 0) ? CMD_OFF : CMD_ON, ch,
                        $urandom_range(0, 255), $urandom_range(0, 1), pick_tcs(),
                        $urandom_range(0, 1)));
        repeat ($urandom_range(1, 30))
          send_cmd(mk_cmd(CMD_RENDER, ($urandom_range(0, 3) == 0) ? pick_channel() : ch,
                          $urandom_range(0, 255), $urandom_range(0, 1),
                          $urandom_range(0, 65535), $urandom_range(0, 1)));
      end else begin
        raw = CMD_W'({$urandom, $urandom});
        send_cmd(raw);
      end
    end
  endtask

  task automatic test_random_fades();
    set_regs(FPS_RESET, DEF_TCS_RESET);
    run_fades(300);
    set_regs(7'd1, 16'd0);
    run_fades(300);
    set_regs(7'd100, 16'hFFFF);
    run_fades(300);
    set_regs(FPS_W'($urandom_range(1, 127)), TCS_W'($urandom_range(0, 400)));
    run_fades(300);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_regs(7'd25, 16'd20);
    run_fades(300);
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected word: out_channel %0d level %0d fade_done %0d",
               res_if.data.out_channel, res_if.data.level, res_if.data.fade_done);
        err_cnt++;
      end else begin
        exp_word = pending_levels.pop_front();
        if (res_if.data.out_channel !== exp_word.out_channel) begin
          $error("out_channel: expected %0d, got %0d", exp_word.out_channel,
                 res_if.data.out_channel);
          err_cnt++;
        end
        if (res_if.data.level !== exp_word.level) begin
          $error("level: expected %0d, got %0d", exp_word.level, res_if.data.level);
          err_cnt++;
        end
        if (res_if.data.fade_done !== exp_word.fade_done) begin
          $error("fade_done: expected %0d, got %0d", exp_word.fade_done,
                 res_if.data.fade_done);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    err_cnt      = 0;
    items_sent   = 0;
    cycle_cnt    = 0;
    reset_model();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_fade_edges();
    test_backpressure();
    test_random_fades();
    settle();
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/dcfe_pkg.sv
sv/dcfe_stream_if.sv
sv/dcfe_mem.sv
sv/dcfe_frames.sv
sv/dcfe_div.sv
sv/dmx_channel_fade_engine_top.sv
sv/dcfe_chk.sv
dv/tb.sv
